### sv/sorted_date_table_range_search_top_macros.svh
// Assertion macros shared by the sorted date table design
`ifndef SORTED_DATE_TABLE_RANGE_SEARCH_TOP_MACROS_SVH
`define SORTED_DATE_TABLE_RANGE_SEARCH_TOP_MACROS_SVH
// same-cycle implication
`define SRTDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SRTDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### sv/srtds_pkg.sv
// Types and codes for the sorted date table
`default_nettype none
package srtds_pkg;
   localparam int DATE_W    = 24;
   localparam int IDX_OUT_W = 10;
   localparam int CNT_OUT_W = 11;

   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_FIND   = 3'd3;
   localparam logic [2:0] OP_RANGE  = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_ORDER     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]        operation;
      logic [DATE_W-1:0] key_date;
      logic [DATE_W-1:0] upper_date;
      logic              use_lower;
      logic              use_upper;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [IDX_OUT_W-1:0] first_index;
      logic [IDX_OUT_W-1:0] last_index;
      logic [CNT_OUT_W-1:0] entry_count;
   } rsp_type;
endpackage
`default_nettype wire

### sv/srtds_ram.sv
// Date store: one write port, one registered read port
`default_nettype none
module srtds_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire                           clock,
   input  wire                           we,
   input  wire  [ADDR_W-1:0]             waddr,
   input  wire  [srtds_pkg::DATE_W-1:0]  wdata,
   input  wire  [ADDR_W-1:0]             raddr,
   output logic [srtds_pkg::DATE_W-1:0]  rdata
);
   logic [srtds_pkg::DATE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### sv/sorted_date_table_range_search_top.sv
// Sorted date table with append, insert, remove, exact and range find
//
//   channel | ports                      | handshake
//   request | start, busy, req_word      | taken when start && !busy
//   result  | rsp_valid, rsp_word        | one-cycle strobe, no back-pressure
//
// One word is processed at a time; busy stays high until its result strobes.
// Each binary search step runs issue, RAM read and compare states on the one
// RAM read port; a range with two different bounds runs two searches. Insert
// and remove shift one entry per read, wait and write states. Reset empties
// the table at once; no clearing pass.
`default_nettype none
`include "sorted_date_table_range_search_top_macros.svh"
module sorted_date_table_range_search_top #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  srtds_pkg::req_type  req_word,
   output logic                rsp_valid,
   output srtds_pkg::rsp_type  rsp_word
);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ALWT  = 4'd1;
   localparam logic [3:0] S_ALCHK = 4'd2;
   localparam logic [3:0] S_SRCH  = 4'd3;
   localparam logic [3:0] S_SWT   = 4'd4;
   localparam logic [3:0] S_SCMP  = 4'd5;
   localparam logic [3:0] S_SHR   = 4'd6;
   localparam logic [3:0] S_SHRW  = 4'd7;
   localparam logic [3:0] S_SHW   = 4'd8;
   localparam logic [3:0] S_SLR   = 4'd9;
   localparam logic [3:0] S_SLRW  = 4'd10;
   localparam logic [3:0] S_SLW   = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0]                   state_ff, state_in;
   srtds_pkg::req_type           req_ff, req_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CNT_W-1:0]             i_ff, i_in;
   logic [CNT_W-1:0]             first_ff, first_in, last_ff, last_in;
   logic [1:0]                   status_ff, status_in;
   logic [IDX_W-1:0]             addr_ff, addr_in;
   logic [srtds_pkg::DATE_W-1:0] key_ff, key_in;
   logic                         le_ff, le_in, match_ff, match_in;
   logic                         upper_ff, upper_in, exact_ff, exact_in;

   logic                         we;
   logic [IDX_W-1:0]             waddr;
   logic [srtds_pkg::DATE_W-1:0] wdata, rdata;
   logic [CNT_W-1:0]             diff, mid;
   logic                         go_lo;
   logic [31:0]                  first_w, last_w, count_w;

   srtds_ram #(.DEPTH(TABLE_DEPTH), .ADDR_W(IDX_W)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (addr_ff),
      .rdata (rdata)
   );

   assign diff  = hi_ff - lo_ff;
   assign mid   = lo_ff + (diff >> 1);
   assign go_lo = le_ff ? (rdata <= key_ff) : (rdata < key_ff);

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      i_in      = i_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      status_in = status_ff;
      addr_in   = addr_ff;
      key_in    = key_ff;
      le_in     = le_ff;
      match_in  = match_ff;
      upper_in  = upper_ff;
      exact_in  = exact_ff;
      we        = 1'b0;
      waddr     = i_ff[IDX_W-1:0];
      wdata     = rdata;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in    = req_word;
               status_in = srtds_pkg::ST_NOT_FOUND;
               first_in  = '0;
               last_in   = '0;
               lo_in     = '0;
               hi_in     = count_ff;
               key_in    = req_word.key_date;
               le_in     = 1'b0;
               match_in  = 1'b0;
               upper_in  = 1'b0;
               exact_in  = 1'b0;
               state_in  = S_DONE;
               case (req_word.operation)
                  srtds_pkg::OP_APPEND: begin
                     if (count_ff >= DEPTH_C) begin
                        status_in = srtds_pkg::ST_FULL;
                     end else if (count_ff == '0) begin
                        we        = 1'b1;
                        waddr     = '0;
                        wdata     = req_word.key_date;
                        count_in  = ONE_C;
                        status_in = srtds_pkg::ST_OK;
                     end else begin
                        addr_in  = IDX_W'(count_ff - ONE_C);
                        state_in = S_ALWT;
                     end
                  end
                  srtds_pkg::OP_INSERT, srtds_pkg::OP_REMOVE, srtds_pkg::OP_FIND: begin
                     state_in = S_SRCH;
                  end
                  srtds_pkg::OP_RANGE: begin
                     if (count_ff != '0) begin
                        if (req_word.use_lower && req_word.use_upper &&
                            req_word.key_date == req_word.upper_date) begin
                           exact_in = 1'b1;
                           state_in = S_SRCH;
                        end else if (req_word.use_lower) begin
                           state_in = S_SRCH;
                        end else if (req_word.use_upper) begin
                           key_in   = req_word.upper_date;
                           le_in    = 1'b1;
                           upper_in = 1'b1;
                           state_in = S_SRCH;
                        end else begin
                           status_in = srtds_pkg::ST_OK;
                           last_in   = count_ff - ONE_C;
                        end
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ALWT: begin
            state_in = S_ALCHK;
         end
         S_ALCHK: begin
            state_in = S_DONE;
            if (req_ff.key_date <= rdata) begin
               status_in = srtds_pkg::ST_ORDER;
            end else begin
               we        = 1'b1;
               waddr     = count_ff[IDX_W-1:0];
               wdata     = req_ff.key_date;
               first_in  = count_ff;
               last_in   = count_ff;
               count_in  = count_ff + ONE_C;
               status_in = srtds_pkg::ST_OK;
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid;
               addr_in  = mid[IDX_W-1:0];
               state_in = S_SWT;
            end else begin
               state_in = S_DONE;
               if (req_ff.operation == srtds_pkg::OP_RANGE && !exact_ff) begin
                  if (!upper_ff) begin
                     if (lo_ff >= count_ff) begin
                        state_in = S_DONE;
                     end else if (req_ff.use_upper) begin
                        first_in = lo_ff;
                        lo_in    = '0;
                        hi_in    = count_ff;
                        key_in   = req_ff.upper_date;
                        le_in    = 1'b1;
                        upper_in = 1'b1;
                        state_in = S_SRCH;
                     end else begin
                        first_in  = lo_ff;
                        last_in   = count_ff - ONE_C;
                        status_in = srtds_pkg::ST_OK;
                     end
                  end else if (lo_ff != '0) begin
                     last_in   = lo_ff - ONE_C;
                     status_in = srtds_pkg::ST_OK;
                  end else begin
                     first_in = '0;
                  end
               end else if (match_ff) begin
                  first_in  = lo_ff;
                  last_in   = lo_ff;
                  status_in = srtds_pkg::ST_OK;
                  if (req_ff.operation == srtds_pkg::OP_REMOVE) begin
                     i_in     = lo_ff;
                     state_in = S_SLR;
                  end
               end else if (req_ff.operation == srtds_pkg::OP_INSERT) begin
                  if (count_ff >= DEPTH_C) begin
                     status_in = srtds_pkg::ST_FULL;
                  end else begin
                     i_in     = count_ff;
                     state_in = S_SHR;
                  end
               end
            end
         end
         S_SWT: begin
            state_in = S_SCMP;
         end
         S_SCMP: begin
            // a hit on the key itself is the lower bound in a strictly rising table
            if (rdata == key_ff) begin
               match_in = 1'b1;
            end
            if (go_lo) begin
               lo_in = mid_ff + ONE_C;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SRCH;
         end
         S_SHR: begin
            if (i_ff > lo_ff) begin
               addr_in  = IDX_W'(i_ff - ONE_C);
               state_in = S_SHRW;
            end else begin
               we        = 1'b1;
               waddr     = lo_ff[IDX_W-1:0];
               wdata     = req_ff.key_date;
               count_in  = count_ff + ONE_C;
               first_in  = lo_ff;
               last_in   = lo_ff;
               status_in = srtds_pkg::ST_OK;
               state_in  = S_DONE;
            end
         end
         S_SHRW: begin
            state_in = S_SHW;
         end
         S_SHW: begin
            // move entry i-1 up into slot i
            we       = 1'b1;
            i_in     = i_ff - ONE_C;
            state_in = S_SHR;
         end
         S_SLR: begin
            if (i_ff + ONE_C < count_ff) begin
               addr_in  = IDX_W'(i_ff + ONE_C);
               state_in = S_SLRW;
            end else begin
               count_in = count_ff - ONE_C;
               state_in = S_DONE;
            end
         end
         S_SLRW: begin
            state_in = S_SLW;
         end
         S_SLW: begin
            // move entry i+1 down into slot i
            we       = 1'b1;
            i_in     = i_ff + ONE_C;
            state_in = S_SLR;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      req_ff    <= req_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      i_ff      <= i_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
      key_ff    <= key_in;
      le_ff     <= le_in;
      match_ff  <= match_in;
      upper_ff  <= upper_in;
      exact_ff  <= exact_in;
   end

   assign first_w = 32'(first_ff);
   assign last_w  = 32'(last_ff);
   assign count_w = 32'(count_ff);

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   always_comb begin
      rsp_word.status      = status_ff;
      rsp_word.first_index = first_w[srtds_pkg::IDX_OUT_W-1:0];
      rsp_word.last_index  = last_w[srtds_pkg::IDX_OUT_W-1:0];
      rsp_word.entry_count = count_w[srtds_pkg::CNT_OUT_W-1:0];
   end

   `SRTDS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
      "accept did not raise busy")
   `SRTDS_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid,
      "result strobe held")
   `SRTDS_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= DEPTH_C,
      "count over depth")
   `SRTDS_ASSERT_NOW(a_ok_range, clock, reset,
      rsp_valid && rsp_word.status == srtds_pkg::ST_OK, first_ff <= count_ff,
      "ok index beyond count")
endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the sorted date table with range search
`timescale 1ns / 1ps
`default_nettype none

class date_table_scoreboard;
   localparam int DEPTH = 1024;
   logic [srtds_pkg::DATE_W-1:0] dates[$];
   srtds_pkg::rsp_type           awaited[$];
   int                           errors;
   int                           checked;

   function new();
      errors  = 0;
      checked = 0;
   endfunction

   function int size();
      return dates.size();
   endfunction

   function logic [srtds_pkg::DATE_W-1:0] last_date();
      return dates[dates.size()-1];
   endfunction

   // first index whose date is at or above k
   function int first_at_or_above(logic [srtds_pkg::DATE_W-1:0] k);
      int lo, hi, mid;
      lo = 0;
      hi = dates.size();
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (dates[mid] < k) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function int count_at_or_below(logic [srtds_pkg::DATE_W-1:0] k);
      int lo, hi, mid;
      lo = 0;
      hi = dates.size();
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (dates[mid] <= k) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   // work out the result of one accepted word and update the table copy
   function void note(srtds_pkg::req_type w);
      srtds_pkg::rsp_type e;
      int                 pos, lo_idx, hi_idx, n;
      bit                 hit, ok;
      e        = '0;
      e.status = srtds_pkg::ST_NOT_FOUND;
      pos      = first_at_or_above(w.key_date);
      hit      = pos < dates.size() && dates[pos] == w.key_date;
      case (w.operation)
         srtds_pkg::OP_APPEND: begin
            if (dates.size() >= DEPTH) e.status = srtds_pkg::ST_FULL;
            else if (dates.size() > 0 && w.key_date <= last_date())
               e.status = srtds_pkg::ST_ORDER;
            else begin
               e.status      = srtds_pkg::ST_OK;
               e.first_index = srtds_pkg::IDX_OUT_W'(dates.size());
               e.last_index  = srtds_pkg::IDX_OUT_W'(dates.size());
               dates.insert(dates.size(), w.key_date);
            end
         end
         srtds_pkg::OP_INSERT: begin
            if (hit) begin
               e.status      = srtds_pkg::ST_OK;
               e.first_index = srtds_pkg::IDX_OUT_W'(pos);
               e.last_index  = srtds_pkg::IDX_OUT_W'(pos);
            end else if (dates.size() >= DEPTH) e.status = srtds_pkg::ST_FULL;
            else begin
               dates.insert(pos, w.key_date);
               e.status      = srtds_pkg::ST_OK;
               e.first_index = srtds_pkg::IDX_OUT_W'(pos);
               e.last_index  = srtds_pkg::IDX_OUT_W'(pos);
            end
         end
         srtds_pkg::OP_REMOVE: begin
            if (hit) begin
               dates.delete(pos);
               e.status      = srtds_pkg::ST_OK;
               e.first_index = srtds_pkg::IDX_OUT_W'(pos);
               e.last_index  = srtds_pkg::IDX_OUT_W'(pos);
            end
         end
         srtds_pkg::OP_FIND: begin
            if (hit) begin
               e.status      = srtds_pkg::ST_OK;
               e.first_index = srtds_pkg::IDX_OUT_W'(pos);
               e.last_index  = srtds_pkg::IDX_OUT_W'(pos);
            end
         end
         srtds_pkg::OP_RANGE: begin
            if (dates.size() == 0) begin
            end else if (w.use_lower && w.use_upper && w.key_date == w.upper_date) begin
               if (hit) begin
                  e.status      = srtds_pkg::ST_OK;
                  e.first_index = srtds_pkg::IDX_OUT_W'(pos);
                  e.last_index  = srtds_pkg::IDX_OUT_W'(pos);
               end
            end else begin
               ok     = 1;
               lo_idx = 0;
               hi_idx = dates.size() - 1;
               if (w.use_lower) begin
                  lo_idx = pos;
                  if (lo_idx >= dates.size()) ok = 0;
               end
               if (w.use_upper) begin
                  n = count_at_or_below(w.upper_date);
                  if (n == 0) ok = 0;
                  else hi_idx = n - 1;
               end
               if (ok) begin
                  e.status      = srtds_pkg::ST_OK;
                  e.first_index = srtds_pkg::IDX_OUT_W'(lo_idx);
                  e.last_index  = srtds_pkg::IDX_OUT_W'(hi_idx);
               end
            end
         end
         default: ;
      endcase
      e.entry_count = srtds_pkg::CNT_OUT_W'(dates.size());
      awaited.insert(awaited.size(), e);
   endfunction

   task report(string what, int got, int want);
      errors++;
      if (errors <= 30)
         $display("mismatch on word %0d: %s got %0d, want %0d", checked, what, got, want);
   endtask

   task check(srtds_pkg::rsp_type r);
      srtds_pkg::rsp_type e;
      if (awaited.size() == 0) begin
         report("unexpected word, status", r.status, 0);
         return;
      end
      e = awaited.pop_front();
      if (r.status !== e.status) report("status", r.status, e.status);
      if (r.first_index !== e.first_index) report("first_index", r.first_index, e.first_index);
      if (r.last_index !== e.last_index) report("last_index", r.last_index, e.last_index);
      if (r.entry_count !== e.entry_count) report("entry_count", r.entry_count, e.entry_count);
      checked++;
   endtask
endclass

module tb;
   localparam int POOL = 80;
   localparam logic [srtds_pkg::DATE_W-1:0] MAX_DATE = '1;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   srtds_pkg::req_type req_word = '0;
   logic               busy;
   logic               rsp_valid;
   srtds_pkg::rsp_type rsp_word;

   date_table_scoreboard         sb = new();
   logic [srtds_pkg::DATE_W-1:0] pool[POOL];
   bit                           gaps_on = 1;
   int                           sent = 0;

   sorted_date_table_range_search_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_word);
   end

   // hold the word until taken, then maybe drop start for an idle burst
   task automatic drive(input srtds_pkg::req_type w);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      sb.note(w);
      sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic op(input logic [2:0] o, input logic [srtds_pkg::DATE_W-1:0] k,
                     input logic [srtds_pkg::DATE_W-1:0] u = '0,
                     input bit ul = 1'b0, input bit uu = 1'b0);
      srtds_pkg::req_type w;
      w.operation  = o;
      w.key_date   = k;
      w.upper_date = u;
      w.use_lower  = ul;
      w.use_upper  = uu;
      drive(w);
   endtask

   function automatic logic [srtds_pkg::DATE_W-1:0] pick_date();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return pool[$urandom_range(0, POOL-1)];
      if (p < 75) return '0;
      if (p < 80) return MAX_DATE;
      return srtds_pkg::DATE_W'($urandom());
   endfunction

   function automatic srtds_pkg::req_type random_word();
      srtds_pkg::req_type w;
      int                 p;
      w.key_date   = pick_date();
      w.upper_date = pick_date();
      w.use_lower  = 1'($urandom());
      w.use_upper  = 1'($urandom());
      p = $urandom_range(0, 99);
      // keep the table short so shifts stay cheap: turn growth into removes
      if (sb.size() > 40 && p >= 5 && p < 40) p = 45;
      if (p < 5) w.operation = 3'($urandom_range(5, 7));
      else if (p < 20) begin
         w.operation = srtds_pkg::OP_APPEND;
         if (sb.size() > 0 && $urandom_range(0, 2) != 0 &&
             sb.last_date() < MAX_DATE - 5000)
            w.key_date = srtds_pkg::DATE_W'(sb.last_date() + $urandom_range(1, 5000));
      end
      else if (p < 40) w.operation = srtds_pkg::OP_INSERT;
      else if (p < 60) w.operation = srtds_pkg::OP_REMOVE;
      else if (p < 75) w.operation = srtds_pkg::OP_FIND;
      else begin
         w.operation = srtds_pkg::OP_RANGE;
         if ($urandom_range(0, 6) == 0) w.upper_date = w.key_date;
      end
      return w;
   endfunction

   initial begin
      #20ms;
      $display("timeout after %0d words sent", sent);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      foreach (pool[i]) pool[i] = srtds_pkg::DATE_W'($urandom());
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, order errors, gaps, bad operations
      op(srtds_pkg::OP_RANGE, '0, MAX_DATE, 1'b1, 1'b1);
      op(srtds_pkg::OP_FIND, '0);
      op(srtds_pkg::OP_REMOVE, '0);
      op(srtds_pkg::OP_APPEND, '0);
      op(srtds_pkg::OP_APPEND, '0);
      op(srtds_pkg::OP_APPEND, 24'h000100);
      op(srtds_pkg::OP_APPEND, MAX_DATE);
      op(srtds_pkg::OP_APPEND, 24'h000200);
      op(srtds_pkg::OP_INSERT, MAX_DATE);
      op(srtds_pkg::OP_INSERT, 24'h000080);
      op(srtds_pkg::OP_INSERT, 24'h800000);
      op(srtds_pkg::OP_FIND, 24'h000100);
      op(srtds_pkg::OP_FIND, 24'h000101);
      op(srtds_pkg::OP_RANGE, 24'h000100, 24'h000100, 1'b1, 1'b1);
      op(srtds_pkg::OP_RANGE, 24'h000101, 24'h000101, 1'b1, 1'b1);
      op(srtds_pkg::OP_RANGE, 24'h000101, 24'h0001FF, 1'b1, 1'b1);
      op(srtds_pkg::OP_RANGE, 24'h000050, 24'h800000, 1'b1, 1'b1);
      op(srtds_pkg::OP_RANGE, MAX_DATE, '0, 1'b0, 1'b0);
      op(srtds_pkg::OP_RANGE, 24'h000081, '0, 1'b1, 1'b0);
      op(srtds_pkg::OP_REMOVE, MAX_DATE);
      op(srtds_pkg::OP_RANGE, 24'h800001, '0, 1'b1, 1'b0);
      op(srtds_pkg::OP_REMOVE, '0);
      op(srtds_pkg::OP_RANGE, '0, '0, 1'b0, 1'b1);
      op(3'd5, 24'h000100);
      op(3'd7, MAX_DATE, MAX_DATE, 1'b1, 1'b1);

      repeat (700) drive(random_word());

      // last part: no idling; random words, then empty the table from the back
      gaps_on = 0;
      repeat (200) drive(random_word());
      while (sb.size() > 0) op(srtds_pkg::OP_REMOVE, sb.last_date());
      op(srtds_pkg::OP_RANGE, MAX_DATE, MAX_DATE, 1'b1, 1'b1);
      op(srtds_pkg::OP_INSERT, MAX_DATE);
      op(srtds_pkg::OP_APPEND, 24'd1);
      op(srtds_pkg::OP_RANGE, '0, '0, 1'b0, 1'b0);
      start <= 1'b0;

      while (sb.awaited.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("sent %0d words, checked %0d results, %0d mismatches", sent, sb.checked,
               sb.errors);
      $display("covered empty and partly filled tables, all operations and range bound mixes");
      if (sb.errors == 0 && sb.awaited.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

`default_nettype wire
